### rtl/core/bfa_pkg.sv
// bfa_pkg: shared constants and types of the bloom filter with adler-32 key hash
// no dependencies; used by bfa_modunit and bloom_filter_adler32_top
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;

  localparam int CHUNK_BITS_DEF   = 16;
  localparam int NUM_PROBES_DEF   = 2;
  localparam int FILTER_BYTES_DEF = 8192;

  localparam int          SUM_W      = 16;
  localparam logic [15:0] ADLER_MOD  = 16'd65521;
  localparam logic [31:0] SALT_RESET = 32'd1;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // operands of the shared add / compare-subtract unit
  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] m;
  } bfa_op_t;

endpackage
`default_nettype wire

### rtl/core/bfa_modunit.sv
// bfa_modunit: shared arithmetic unit, r = (a + b) >= m ? a + b - m : a + b
// depends on bfa_pkg (operand struct, sum width)
`timescale 1ns / 1ps
`default_nettype none
module bfa_modunit (
  input  var bfa_pkg::bfa_op_t          op,
  output logic [bfa_pkg::SUM_W-1:0]     res
);

  logic [bfa_pkg::SUM_W:0] sum;
  logic [bfa_pkg::SUM_W:0] diff;

  always_comb begin
    sum  = {1'b0, op.a} + {1'b0, op.b};
    diff = sum - {1'b0, op.m};
    // single correction: callers keep a + b below twice m
    if (sum >= {1'b0, op.m}) begin
      res = diff[bfa_pkg::SUM_W-1:0];
    end else begin
      res = sum[bfa_pkg::SUM_W-1:0];
    end
  end

endmodule
`default_nettype wire

### rtl/core/bfa_mem.sv
// bfa_mem: single-port byte store of the filter, registered read data
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none
module bfa_mem #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/core/bloom_filter_adler32_top.sv
// bloom_filter_adler32_top: two-probe bloom filter keyed by an adler-32 hash
// depends on bfa_pkg, bfa_modunit, bfa_mem
//
// usage
//   input: one key byte per transaction (in_action, in_key_byte,
//   in_last_byte), taken at a clock edge with start high and busy low.
//   keys stream byte by byte; in_last_byte marks the final byte, and only
//   the action given with that byte counts.
//   result: on a final byte only, out_was_query / out_present appear for
//   exactly one cycle with out_strobe high; the receiver cannot stall, so
//   the result is simply gone after that cycle.
//   config: cfg_we / cfg_wdata write hash_salt (reset value 1); write it
//   only while idle. a new salt is used from the next key's first byte.
// sequence
//   every byte goes through the one shared add / compare-subtract unit:
//   a non-first byte takes the steps SUM_A and SUM_B; the first byte of a
//   key takes SEED_A and SEED_B before them (two extra steps reduce the
//   salt halves mod 65521). a final byte then adds, per probe, a chunk
//   select, RED_STEPS index reductions by the same unit, a memory read
//   and an update; RED_STEPS is 0 for the default store size. the strobe
//   comes in the cycle after the last update, when busy is already low.
// reset
//   synchronous, active low. afterwards the block runs a clearing pass
//   over the store, one byte a cycle, through all FILTER_BYTES bytes (8192 by
//   default), and holds busy high until it is done.
`timescale 1ns / 1ps
`default_nettype none
module bloom_filter_adler32_top #(
  parameter int CHUNK_BITS   = bfa_pkg::CHUNK_BITS_DEF,
  parameter int NUM_PROBES   = bfa_pkg::NUM_PROBES_DEF,
  parameter int FILTER_BYTES = bfa_pkg::FILTER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last_byte,
  // result channel
  output logic        out_strobe,
  output logic        out_was_query,
  output logic        out_present,
  // configuration
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int SW        = bfa_pkg::SUM_W;
  localparam int IDXW      = CHUNK_BITS - 3;
  localparam int IDX_SPAN  = 1 << IDXW;
  localparam int AW        = (FILTER_BYTES > 1) ? $clog2(FILTER_BYTES) : 1;
  localparam int RED_STEPS = (FILTER_BYTES >= IDX_SPAN) ? 0 :
                             $clog2((IDX_SPAN + FILTER_BYTES - 1) / FILTER_BYTES);
  localparam int RCW       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam int PW        = (NUM_PROBES > 1) ? $clog2(NUM_PROBES) : 1;

  // sequencer states, one-hot
  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b00_0000_0001,
    ST_IDLE   = 10'b00_0000_0010,
    ST_SEED_A = 10'b00_0000_0100,
    ST_SEED_B = 10'b00_0000_1000,
    ST_SUM_A  = 10'b00_0001_0000,
    ST_SUM_B  = 10'b00_0010_0000,
    ST_CHUNK  = 10'b00_0100_0000,
    ST_REDUCE = 10'b00_1000_0000,
    ST_READ   = 10'b01_0000_0000,
    ST_UPDATE = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // control registers
  logic [31:0]     salt_r, salt_nxt;
  logic            in_key_r, in_key_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [PW-1:0]   probe_r, probe_nxt;
  logic [RCW-1:0]  red_cnt_r, red_cnt_nxt;
  logic            out_strobe_r, out_strobe_nxt;

  // payload registers
  logic            action_r, action_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            last_r, last_nxt;
  logic [SW-1:0]   sum_low_r, sum_low_nxt;
  logic [SW-1:0]   sum_high_r, sum_high_nxt;
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic [2:0]      bit_r, bit_nxt;
  logic            present_r, present_nxt;
  logic            out_was_query_r, out_was_query_nxt;
  logic            out_present_r, out_present_nxt;

  // shared unit and store
  bfa_pkg::bfa_op_t unit_op;
  logic [SW-1:0]    unit_res;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [7:0]       mem_wdata;
  logic [7:0]       mem_rdata;

  logic [31:0]           hash;
  logic [CHUNK_BITS-1:0] chunk;
  logic [7:0]            bit_mask;
  logic                  hit;
  logic                  last_probe;

  bfa_modunit u_modunit (
    .op  (unit_op),
    .res (unit_res)
  );

  bfa_mem #(
    .DEPTH (FILTER_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign hash       = {sum_high_r, sum_low_r};
  // probe 0 takes the low chunk, probe 1 the next one up
  assign chunk      = (probe_r == '0) ? hash[CHUNK_BITS-1:0]
                                      : hash[2*CHUNK_BITS-1:CHUNK_BITS];
  assign bit_mask   = 8'd1 << bit_r;
  assign hit        = (mem_rdata & bit_mask) != 8'd0;
  assign last_probe = (probe_r == PW'(NUM_PROBES - 1));

  // operand select of the shared unit
  always_comb begin
    unit_op.a = sum_low_r;
    unit_op.b = {{(SW-8){1'b0}}, byte_r};
    unit_op.m = bfa_pkg::ADLER_MOD;
    case (state_r)
      ST_SEED_A: begin
        unit_op.a = salt_r[15:0];
        unit_op.b = '0;
      end
      ST_SEED_B: begin
        unit_op.a = salt_r[31:16];
        unit_op.b = '0;
      end
      ST_SUM_B: begin
        unit_op.a = sum_high_r;
        unit_op.b = sum_low_r;
      end
      ST_REDUCE: begin
        // subtract store size shifted up when the index is at or above it
        unit_op.a = SW'(idx_r);
        unit_op.b = '0;
        unit_op.m = SW'(FILTER_BYTES) << red_cnt_r;
      end
      default: begin
      end
    endcase
  end

  // store port
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = AW'(idx_r);
    mem_wdata = mem_rdata | bit_mask;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = 8'd0;
      end
      ST_UPDATE: begin
        mem_we = (action_r == bfa_pkg::ACT_ADD);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    salt_nxt          = cfg_we ? cfg_wdata : salt_r;
    in_key_nxt        = in_key_r;
    clr_cnt_nxt       = clr_cnt_r;
    probe_nxt         = probe_r;
    red_cnt_nxt       = red_cnt_r;
    out_strobe_nxt    = 1'b0;
    action_nxt        = action_r;
    byte_nxt          = byte_r;
    last_nxt          = last_r;
    sum_low_nxt       = sum_low_r;
    sum_high_nxt      = sum_high_r;
    idx_nxt           = idx_r;
    bit_nxt           = bit_r;
    present_nxt       = present_r;
    out_was_query_nxt = out_was_query_r;
    out_present_nxt   = out_present_r;

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(FILTER_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          action_nxt = in_action;
          byte_nxt   = in_key_byte;
          last_nxt   = in_last_byte;
          state_nxt  = in_key_r ? ST_SUM_A : ST_SEED_A;
        end
      end
      ST_SEED_A: begin
        sum_low_nxt = unit_res;
        state_nxt   = ST_SEED_B;
      end
      ST_SEED_B: begin
        sum_high_nxt = unit_res;
        state_nxt    = ST_SUM_A;
      end
      ST_SUM_A: begin
        sum_low_nxt = unit_res;
        state_nxt   = ST_SUM_B;
      end
      ST_SUM_B: begin
        sum_high_nxt = unit_res;
        in_key_nxt   = !last_r;
        probe_nxt    = '0;
        present_nxt  = 1'b1;
        state_nxt    = last_r ? ST_CHUNK : ST_IDLE;
      end
      ST_CHUNK: begin
        idx_nxt     = chunk[CHUNK_BITS-1:3];
        bit_nxt     = chunk[2:0];
        red_cnt_nxt = RCW'((RED_STEPS > 0) ? RED_STEPS - 1 : 0);
        state_nxt   = (RED_STEPS > 0) ? ST_REDUCE : ST_READ;
      end
      ST_REDUCE: begin
        idx_nxt     = unit_res[IDXW-1:0];
        red_cnt_nxt = red_cnt_r - RCW'(1);
        if (red_cnt_r == '0) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (action_r == bfa_pkg::ACT_QUERY && !hit) begin
          present_nxt = 1'b0;
        end
        if (last_probe) begin
          out_strobe_nxt    = 1'b1;
          out_was_query_nxt = action_r;
          out_present_nxt   = (action_r == bfa_pkg::ACT_ADD) ? 1'b1 : (present_r & hit);
          state_nxt         = ST_IDLE;
        end else begin
          probe_nxt = probe_r + PW'(1);
          state_nxt = ST_CHUNK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      salt_r       <= bfa_pkg::SALT_RESET;
      in_key_r     <= 1'b0;
      clr_cnt_r    <= '0;
      probe_r      <= '0;
      red_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      salt_r       <= salt_nxt;
      in_key_r     <= in_key_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      probe_r      <= probe_nxt;
      red_cnt_r    <= red_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    action_r        <= action_nxt;
    byte_r          <= byte_nxt;
    last_r          <= last_nxt;
    sum_low_r       <= sum_low_nxt;
    sum_high_r      <= sum_high_nxt;
    idx_r           <= idx_nxt;
    bit_r           <= bit_nxt;
    present_r       <= present_nxt;
    out_was_query_r <= out_was_query_nxt;
    out_present_r   <= out_present_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_strobe    = out_strobe_r;
  assign out_was_query = out_was_query_r;
  assign out_present   = out_present_r;

endmodule
`default_nettype wire

### rtl/core/bfa_checker.sv
// bfa_checker: port-level checks of the bloom filter top level, with its bind
// depends on bloom_filter_adler32_top (bind target)
`timescale 1ns / 1ps
`default_nettype none
module bfa_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_was_query,
  input logic out_present
);

  // reset starts the clearing pass, so no transaction is taken right after
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  // an accepted transaction always occupies the sequencer for a while
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_strobe))
    else $error("accepted transaction did not hold busy");

  // a result comes out only once the sequencer is back to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (!busy && $past(busy)))
    else $error("result strobe while busy");

  // results are single-cycle and separated by work
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  // an add always reports present
  a_add_present: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_was_query) |-> out_present)
    else $error("add result without present");

endmodule

bind bloom_filter_adler32_top bfa_checker u_bfa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_was_query (out_was_query),
  .out_present   (out_present)
);
`default_nettype wire
